[rtl/kpms_pkg.sv]
// kpms_pkg: word and link types shared by the key/payload sorter.
// No dependencies; used by kpms_cell and key_payload_merge_sort_core.
`default_nettype none

package kpms_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

  // Input word: one record.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             batch_end;
  } in_word_t;

  // Output word: one sorted record.
  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [PAY_W-1:0] sorted_payload;
    logic             run_end;
    logic             dropped;
  } out_word_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    rec_t rec;
    logic valid;
    logic place;   // new record belongs at or before this cell
  } cell_link_t;

  // Broadcast control to every cell.
  typedef struct packed {
    logic ins;     // insert new_rec this cycle
    logic drain;   // shift the chain toward cell 0
    rec_t new_rec;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/key_payload_merge_sort_core.sv]
// key_payload_merge_sort_core: stable key/payload batch sorter, top level.
// Depends on kpms_pkg and kpms_cell.
//
// Records enter one word per cycle while record_stall is low and drop
// straight into their sorted place in a chain of CAPACITY cells: every cell
// compares the incoming key with its own and, where the record goes in ahead
// of it, takes its left neighbor's record, so the chain stays in ascending
// order with equal keys in load order. Records past CAPACITY are discarded
// and the batch's last output word carries dropped. The word with batch_end
// is inserted like any other; from the next cycle the core drains, shifting
// the chain toward cell 0 and giving one sorted word per cycle through an
// output register while the sink does not stall. record_stall is high for
// the whole drain; the next batch may start loading while the last sorted
// word still waits in the output register.
`default_nettype none

module key_payload_merge_sort_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // record side
  input  wire logic               record_valid,
  output logic                    record_stall,
  input  wire kpms_pkg::in_word_t record,
  // sorted side
  output logic                    sorted_valid,
  input  wire logic               sorted_stall,
  output kpms_pkg::out_word_t     sorted
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Batch control
  logic [CNT_W-1:0] fill_count;
  logic             overflow_seen;
  logic             draining;

  logic             rec_take;
  logic             full;
  logic             out_load;
  logic             last_load;

  kpms_pkg::cell_ctl_t  ctl;
  kpms_pkg::cell_link_t links [CAPACITY];
  logic [CAPACITY-1:0]  cell_valid;

  assign record_stall = draining;
  assign rec_take     = record_valid && !record_stall;
  assign full         = (fill_count == CNT_W'(CAPACITY));

  // Drain advances whenever the output register is free or being emptied.
  assign out_load  = draining && (!sorted_valid || !sorted_stall);
  // Cell 1 empty: the word leaving cell 0 is the last of the batch.
  assign last_load = out_load && !links[1].valid;

  assign ctl.ins     = rec_take && !full;
  assign ctl.drain   = out_load;
  assign ctl.new_rec = '{key: record.key, payload: record.payload};

  // Insertion chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kpms_pkg::cell_link_t left_l;
    kpms_pkg::cell_link_t right_l;

    if (i == 0) begin : g_first
      assign left_l = '0;
    end else begin : g_left
      assign left_l = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_l = '0;
    end else begin : g_right
      assign right_l = links[i+1];
    end

    kpms_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (left_l),
      .right (right_l),
      .link  (links[i])
    );

    assign cell_valid[i] = links[i].valid;
  end

  // Batch bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      draining      <= 1'b0;
    end else begin
      if (last_load) begin
        fill_count    <= '0;
        overflow_seen <= 1'b0;
        draining      <= 1'b0;
      end else if (rec_take) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          fill_count <= fill_count + CNT_W'(1);
        end
        if (record.batch_end) begin
          draining <= 1'b1;
        end
      end
    end
  end

  // Output register: holds one sorted word until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      sorted_valid <= 1'b0;
    end else if (out_load) begin
      sorted_valid <= 1'b1;
    end else if (!sorted_stall) begin
      sorted_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sorted.sorted_key     <= links[0].rec.key;
      sorted.sorted_payload <= links[0].rec.payload;
      sorted.run_end        <= last_load;
      sorted.dropped        <= last_load && overflow_seen;
    end
  end

  // Checks
  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid & (cell_valid + CAPACITY'(1))) == '0))
    else $error("chain holds a gap between occupied cells");

  // The count is held through the drain while the chain empties.
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    !draining |-> ($countones(cell_valid) == int'(fill_count)))
    else $error("fill count disagrees with occupied cells");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (sorted_valid && !sorted.run_end && links[0].valid)
      |-> (sorted.sorted_key <= links[0].rec.key))
    else $error("sorted output out of order");

  a_dropped_last: assert property (@(posedge clk) disable iff (rst)
    (sorted_valid && sorted.dropped) |-> sorted.run_end)
    else $error("dropped flag on a word that does not end the run");

endmodule

`default_nettype wire

[rtl/kpms_cell.sv]
// kpms_cell: one slot of the insertion chain, holds one record.
// Depends on kpms_pkg.
`default_nettype none

module kpms_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kpms_pkg::cell_ctl_t ctl,
  input  wire kpms_pkg::cell_link_t left,
  input  wire kpms_pkg::cell_link_t right,
  output kpms_pkg::cell_link_t     link
);

  kpms_pkg::rec_t rec;
  logic           valid;
  logic           place;

  // Strict less-than keeps equal keys in load order.
  assign place = !valid || (ctl.new_rec.key < rec.key);

  assign link.rec   = rec;
  assign link.valid = valid;
  assign link.place = place;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      rec   <= right.rec;
      valid <= right.valid;
    end else if (ctl.ins && place) begin
      if (left.place) begin
        rec   <= left.rec;
        valid <= left.valid;
      end else begin
        rec   <= ctl.new_rec;
        valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sim/key_payload_merge_sort_core_tb.sv]
// key_payload_merge_sort_core_tb: self-checking bench for the key/payload batch sorter.
// Depends on rtl/kpms_pkg.sv, rtl/key_payload_merge_sort_core.sv and rtl/kpms_cell.sv.
// Drives record batches with random gaps, predicts the stable sorted stream, checks each word.
`default_nettype none

module key_payload_merge_sort_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned IDLE_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int unsigned TAIL       = CAPACITY + 16;
  localparam int unsigned RAND_WORDS = 93;

  // Key ranges for random batches.
  typedef enum int {
    KEYS_FULL,   // whole 32-bit range
    KEYS_FEW,    // 0..7, lots of ties
    KEYS_TOP,    // just under 2^32
    KEYS_SPLIT   // 0..5, with bit 31 clear or set
  } key_mix_e;

  // Predicts the sorted stream. Records are kept in sorted order as they
  // arrive: a new one goes after every held record with a key <= its own,
  // which keeps equal keys in load order.
  class sorted_batch_board;
    int unsigned         capacity;
    kpms_pkg::rec_t      held[$];
    bit                  lost;
    kpms_pkg::out_word_t expected_words[$];
    int unsigned         failures;

    function new(int unsigned cap);
      capacity = cap;
      lost     = 1'b0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void note_record(kpms_pkg::in_word_t w);
      int                  pos;
      kpms_pkg::rec_t      r;
      kpms_pkg::out_word_t o;
      if (held.size() < capacity) begin
        r.key     = w.key;
        r.payload = w.payload;
        pos = held.size();
        while (pos > 0 && held[pos-1].key > w.key) pos--;
        held.insert(pos, r);
      end else begin
        lost = 1'b1;  // batch full, word thrown away (batch_end word too)
      end
      if (w.batch_end) begin
        foreach (held[i]) begin
          o.sorted_key     = held[i].key;
          o.sorted_payload = held[i].payload;
          o.run_end        = (i == held.size() - 1);
          o.dropped        = o.run_end && lost;
          expected_words.push_back(o);
        end
        held.delete();
        lost = 1'b0;
      end
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        failures++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_sorted(kpms_pkg::out_word_t got);
      kpms_pkg::out_word_t exp_w;
      if (expected_words.size() == 0) begin
        failures++;
        $display("%0t: unexpected sorted word: expected none, actual %h", $time, got);
        return;
      end
      exp_w = expected_words.pop_front();
      report("sorted_key", exp_w.sorted_key, got.sorted_key);
      report("sorted_payload", exp_w.sorted_payload, got.sorted_payload);
      report("run_end", 32'(exp_w.run_end), 32'(got.run_end));
      report("dropped", 32'(exp_w.dropped), 32'(got.dropped));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                record_valid;
  logic                record_stall;
  kpms_pkg::in_word_t  record;
  logic                sorted_valid;
  logic                sorted_stall;
  kpms_pkg::out_word_t sorted;

  sorted_batch_board board = new(CAPACITY);

  bit          calm;         // when set, neither side idles
  int unsigned stall_left;
  int unsigned idle_cycles;

  key_payload_merge_sort_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .record_valid(record_valid),
    .record_stall(record_stall),
    .record      (record),
    .sorted_valid(sorted_valid),
    .sorted_stall(sorted_stall),
    .sorted      (sorted)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_key(key_mix_e mix);
    case (mix)
      KEYS_FEW:   return 32'($urandom_range(0, 7));
      KEYS_TOP:   return 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
      KEYS_SPLIT: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 5))};
      default:    return $urandom;
    endcase
  endfunction

  function automatic kpms_pkg::in_word_t make_word(logic [31:0] k, logic [31:0] p,
                                                   logic last);
    kpms_pkg::in_word_t w;
    w.key       = k;
    w.payload   = p;
    w.batch_end = last;
    return w;
  endfunction

  // Offer one record word and hold it until the sorter takes it. The word
  // is only noted once accepted; a gap afterwards drops valid for a while.
  task automatic send_record(kpms_pkg::in_word_t w);
    int unsigned gap;
    record_valid <= 1'b1;
    record       <= w;
    do @(posedge clk); while (record_stall);
    board.note_record(w);
    gap = pick_gap();
    if (gap != 0) begin
      record_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random batch: keys from one mix, payloads fully random.
  task automatic send_batch(int unsigned count, key_mix_e mix);
    for (int unsigned i = 0; i < count; i++)
      send_record(make_word(pick_key(mix), $urandom, i == count - 1));
  endtask

  // Sender holds off until every predicted word has come out.
  task automatic wait_drained();
    record_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Sink side: check every accepted sorted word, then pick the next stall.
  // A stall run is always followed by an open cycle.
  always @(posedge clk) begin
    if (rst) begin
      sorted_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (sorted_valid && !sorted_stall) board.check_sorted(sorted);
      if (stall_left != 0) begin
        sorted_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else begin
        sorted_stall <= 1'b0;
        stall_left   <= pick_gap();
      end
    end
  end

  // Watchdog: gives up after too long with nothing moving on either side.
  always @(posedge clk) begin
    if (rst || (record_valid && !record_stall) || (sorted_valid && !sorted_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("key_payload_merge_sort_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned count;
    int unsigned r;
    key_mix_e    mix;

    rst          <= 1'b1;
    record_valid <= 1'b0;
    record       <= '0;
    calm         = 1'b0;
    random_sent  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: a batch of one record
    send_record(make_word(32'h0, 32'h0, 1'b1));

    // Extreme keys, ties at 0, 2^31 and all-ones, keys on both sides of 2^31
    send_record(make_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    send_record(make_word(32'h0000_0000, 32'h0000_0000, 1'b0));
    send_record(make_word(32'h8000_0000, 32'h0000_0001, 1'b0));
    send_record(make_word(32'h7FFF_FFFF, 32'h0000_0002, 1'b0));
    send_record(make_word(32'hFFFF_FFFF, 32'h0000_0003, 1'b0));
    send_record(make_word(32'h0000_0000, 32'hAAAA_AAAA, 1'b0));
    send_record(make_word(32'h8000_0000, 32'h5555_5555, 1'b0));
    send_record(make_word(32'h0000_0001, 32'h0000_0004, 1'b1));

    // All keys equal: output must keep load order
    send_record(make_word(32'h5, 32'h10, 1'b0));
    send_record(make_word(32'h5, 32'h11, 1'b0));
    send_record(make_word(32'h5, 32'h12, 1'b0));
    send_record(make_word(32'h5, 32'h13, 1'b1));

    // Strictly descending input
    send_record(make_word(32'h3, 32'h0, 1'b0));
    send_record(make_word(32'h2, 32'h1, 1'b0));
    send_record(make_word(32'h1, 32'h2, 1'b0));
    send_record(make_word(32'h0, 32'h3, 1'b1));

    // Let the directed batches drain completely before going on
    wait_drained();

    // Overfull batch: CAPACITY records stored, the batch_end word is dropped
    send_batch(CAPACITY + 1, KEYS_FEW);
    random_sent += CAPACITY + 1;

    // Random batches, mostly small; the last one is trimmed to the budget
    while (random_sent < RAND_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      count = $urandom_range(1, 6);
      else if (r < 95) count = $urandom_range(7, 20);
      else             count = $urandom_range(30, CAPACITY);
      if (count > RAND_WORDS - random_sent) count = RAND_WORDS - random_sent;
      mix  = key_mix_e'($urandom_range(0, 3));
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) wait_drained();
      send_batch(count, mix);
      random_sent += count;
    end
    calm = 1'b0;

    // Flush: wait for the last words, then watch for strays
    wait_drained();
    repeat (TAIL) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("key_payload_merge_sort_core_tb: PASS");
    end else begin
      $display("key_payload_merge_sort_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
